// ----- rtl/core/acdp_pkg.sv -----
package acdp_pkg;

  localparam int unsigned PERIOD_MAX_DEF = 63;
  localparam int unsigned RING_DEPTH_DEF = 128;

  localparam int unsigned PRICE_W  = 32;
  localparam int unsigned DIFF_W   = 33;
  localparam int unsigned MAG_W    = 32;
  localparam int unsigned PERIOD_W = 6;
  localparam int unsigned CFG_W    = 6;
  localparam int unsigned LIMB_W   = 32;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  localparam logic [CFG_W-1:0] MIN_LAG_RST = 6'd10;
  localparam logic [CFG_W-1:0] MAX_LAG_RST = 6'd40;

  localparam int unsigned LAG_FLOOR   = 5;
  localparam int unsigned LAG_GAP     = 2;
  localparam int unsigned MIN_PAIRS   = 4;
  localparam int unsigned MIN_SAMPLES = 4;

  typedef enum logic {
    REG_MIN_LAG = 1'b0,
    REG_MAX_LAG = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SETUP,
    ST_LAG,
    ST_PA,
    ST_PB,
    ST_PC,
    ST_PD,
    ST_PE,
    ST_FLOAD,
    ST_FMUL,
    ST_FPOST,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    F_NSXY,
    F_SXSY,
    F_NSXX,
    F_SXSX,
    F_NSYY,
    F_SYSY,
    F_NUM2,
    F_DEN,
    F_LHS,
    F_RHS
  } fin_e;

endpackage

// ----- rtl/core/acdp_ram.sv -----
module acdp_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/autocorr_dominant_period.sv -----
// Dominant cycle period estimator. Each input beat carries one price sample;
// each output beat carries one period estimate, one for every sample.
// Both channels use valid/ready. The period limits min_lag (address 0) and
// max_lag (address 4) are to be written over the APB port only while the
// block is idle; the block itself does not enforce this. The block keeps a
// ring of first differences and, for every lag in range, correlates the
// window of differences with its lagged copy. All products and the correlation
// compare run on one shared 32x32 multiplier under a sequencer. When fewer
// than four samples are held or the history is still short, no lag is
// evaluated. Otherwise each pair of an evaluated lag passes through the
// states PA to PE, as the ring has a single read port and the three
// products share the one multiplier; the first lag needs no compare.
// The input is not ready while a sample is in work. A finished result sits in
// an output register, so the next sample is taken even while the receiver
// stalls; the block then waits before delivering the following result.
// Reset empties the history and restores the default limits; no clearing
// pass is needed.
module autocorr_dominant_period #(
  parameter int unsigned PERIOD_MAX = acdp_pkg::PERIOD_MAX_DEF,
  parameter int unsigned RING_DEPTH = acdp_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [acdp_pkg::APB_AW-1:0]   paddr,
  input  logic [acdp_pkg::APB_DW-1:0]   pwdata,
  output logic [acdp_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [acdp_pkg::PRICE_W-1:0]  price_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [acdp_pkg::PERIOD_W-1:0] period_o
);
  import acdp_pkg::*;

  localparam int unsigned PTR_W     = $clog2(RING_DEPTH);
  localparam int unsigned LAG_W     = $clog2(PERIOD_MAX + 2);
  localparam int unsigned COUNT_CAP = 2 * PERIOD_MAX + 2;
  localparam int unsigned CNT_W     = $clog2(COUNT_CAP + 1);
  localparam int unsigned N_W       = $clog2(2 * PERIOD_MAX + 1);
  localparam int unsigned SUM_W     = DIFF_W + N_W;
  localparam int unsigned SQ_W      = 2 * MAG_W + N_W;
  localparam int unsigned NUM_W     = 2 * MAG_W + 2 * N_W + 1;
  localparam int unsigned SQR_W     = 2 * NUM_W;
  localparam int unsigned LQ        = (SQR_W + LIMB_W - 1) / LIMB_W;
  localparam int unsigned OP_W      = LQ * LIMB_W;
  localparam int unsigned ACC_W     = 2 * OP_W;
  localparam int unsigned IX_W      = (LQ > 1) ? $clog2(LQ) : 1;
  localparam int unsigned SH_W      = $clog2(ACC_W);
  localparam int unsigned LI_N      = 0;
  localparam int unsigned LI_S      = (SUM_W + LIMB_W - 1) / LIMB_W - 1;
  localparam int unsigned LI_Q      = (SQ_W + LIMB_W - 1) / LIMB_W - 1;
  localparam int unsigned LI_M      = (NUM_W + LIMB_W - 1) / LIMB_W - 1;
  localparam int unsigned LI_R      = LQ - 1;
  localparam int unsigned CW        = ((LAG_W > CFG_W) ? LAG_W : CFG_W) + 2;
  localparam int unsigned XW        = CW + CNT_W;

  state_e state_q, state_d;
  fin_e   fin_q, fin_d;

  logic [CFG_W-1:0]         min_lag_q, max_lag_q;
  logic [PRICE_W-1:0]       price_q, price_d;
  logic [PRICE_W-1:0]       last_q, last_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [PTR_W-1:0]         head_q, head_d;
  logic [LAG_W-1:0]         emax_q, emax_d;
  logic [LAG_W-1:0]         lag_q, lag_d, best_q, best_d;
  logic [CNT_W-1:0]         span_q, span_d;
  logic [N_W-1:0]           n_q, n_d, k_q, k_d;
  logic [PTR_W-1:0]         xaddr_q, xaddr_d, yaddr_q, yaddr_d;
  logic signed [DIFF_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [SUM_W-1:0]  sx_q, sx_d, sy_q, sy_d;
  logic [SQ_W-1:0]          sxx_q, sxx_d, syy_q, syy_d;
  logic signed [SQ_W:0]     sxy_q, sxy_d;
  logic [OP_W-1:0]          opa_q, opa_d, opb_q, opb_d;
  logic [IX_W-1:0]          la_q, la_d, lb_q, lb_d, i_q, i_d, j_q, j_d;
  logic [ACC_W-1:0]         acc_q, acc_d, lhs_q, lhs_d;
  logic signed [NUM_W:0]    t1_q, t1_d, num_q, num_d;
  logic [NUM_W-1:0]         dl_q, dl_d, dr_q, dr_d;
  logic [SQR_W-1:0]         n2_q, n2_d, d_q, d_d, bn2_q, bn2_d, bd_q, bd_d;
  logic                     have_q, have_d;
  logic                     out_valid_q, out_valid_d;
  logic [PERIOD_W-1:0]      period_q, period_d;

  logic                     ram_we;
  logic [PTR_W-1:0]         ram_raddr;
  logic [DIFF_W-1:0]        ram_wdata, ram_rdata;

  logic [CW-1:0]            emin_w, emax_w;
  logic [XW-1:0]            idx_w, win_w, start_w, span_w, pairs_w;
  logic                     early, lag_fits;
  logic [MAG_W-1:0]         xmag, ymag, mul_a, mul_b;
  logic [2*LIMB_W-1:0]      mul_p;
  logic [SH_W-1:0]          shamt;
  logic [ACC_W-1:0]         acc_add;
  logic                     mul_last;
  logic [SUM_W-1:0]         sxmag, symag;
  logic [SQ_W-1:0]          sxymag;
  logic [NUM_W-1:0]         nummag, dr_new;
  logic signed [NUM_W:0]    accn;
  logic                     zero_den, to_cmp;
  logic [SQR_W-1:0]         n2_nx, d_nx;
  logic signed [DIFF_W-1:0] xneg, yneg;
  logic signed [SUM_W-1:0]  sxneg, syneg;
  logic signed [SQ_W:0]     sxyneg, pp_s;
  logic signed [NUM_W:0]    numneg;
  logic [PTR_W:0]           ybase;

  acdp_ram #(
    .WIDTH (DIFF_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign pready = 1'b1;

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_MIN_LAG: prdata = APB_DW'(min_lag_q);
      REG_MAX_LAG: prdata = APB_DW'(max_lag_q);
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    emin_w = CW'(min_lag_q);
    if (emin_w < CW'(LAG_FLOOR)) begin
      emin_w = CW'(LAG_FLOOR);
    end
    if (emin_w > CW'(PERIOD_MAX - 2)) begin
      emin_w = CW'(PERIOD_MAX - 2);
    end
    emax_w = CW'(max_lag_q);
    if (emax_w < emin_w + CW'(LAG_GAP)) begin
      emax_w = emin_w + CW'(LAG_GAP);
    end
    if (emax_w > CW'(PERIOD_MAX)) begin
      emax_w = CW'(PERIOD_MAX);
    end
  end

  assign idx_w   = XW'(cnt_q) - XW'(1);
  assign win_w   = XW'(emax_w) << 1;
  assign start_w = (idx_w > win_w) ? idx_w - win_w : XW'(1);
  assign span_w  = idx_w - start_w;
  assign early   = (cnt_q < CNT_W'(MIN_SAMPLES)) || (idx_w < XW'(emax_w) + XW'(LAG_GAP));

  assign pairs_w  = XW'(span_q) - XW'(lag_q) + XW'(1);
  assign lag_fits = (XW'(lag_q) <= XW'(span_q)) && (pairs_w >= XW'(MIN_PAIRS));

  assign xneg = -x_q;
  assign yneg = -y_q;
  assign xmag = x_q[DIFF_W-1] ? xneg[MAG_W-1:0] : x_q[MAG_W-1:0];
  assign ymag = y_q[DIFF_W-1] ? yneg[MAG_W-1:0] : y_q[MAG_W-1:0];

  assign sxneg  = -sx_q;
  assign syneg  = -sy_q;
  assign sxmag  = sx_q[SUM_W-1] ? sxneg : sx_q;
  assign symag  = sy_q[SUM_W-1] ? syneg : sy_q;
  assign sxyneg = -sxy_q;
  assign sxymag = sxy_q[SQ_W] ? sxyneg[SQ_W-1:0] : sxy_q[SQ_W-1:0];
  assign numneg = -num_q;
  assign nummag = num_q[NUM_W] ? numneg[NUM_W-1:0] : num_q[NUM_W-1:0];

  always_comb begin
    case (state_q)
      ST_PC: begin
        mul_a = xmag;
        mul_b = xmag;
      end
      ST_PD: begin
        mul_a = ymag;
        mul_b = ymag;
      end
      ST_PE: begin
        mul_a = xmag;
        mul_b = ymag;
      end
      default: begin
        mul_a = opa_q[i_q*LIMB_W +: LIMB_W];
        mul_b = opb_q[j_q*LIMB_W +: LIMB_W];
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign shamt    = SH_W'((32'(i_q) + 32'(j_q)) * LIMB_W);
  assign acc_add  = acc_q + (ACC_W'(mul_p) << shamt);
  assign mul_last = (i_q == la_q) && (j_q == lb_q);
  assign pp_s     = $signed((SQ_W + 1)'(mul_p));

  assign accn     = $signed(acc_q[NUM_W:0]);
  assign dr_new   = NUM_W'(t1_q - accn);
  assign zero_den = (dl_q == '0) || (dr_new == '0);
  assign to_cmp   = ((fin_q == F_SYSY) && zero_den) || (fin_q == F_DEN);
  assign n2_nx    = (fin_q == F_DEN) ? n2_q : '0;
  assign d_nx     = (fin_q == F_DEN) ? acc_q[SQR_W-1:0] : SQR_W'(1);

  assign ybase = {1'b0, head_q} - (PTR_W + 1)'(lag_q) - (PTR_W + 1)'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_UPDATE;
      end
      ST_UPDATE: state_d = ST_SETUP;
      ST_SETUP: begin
        state_d = early ? ST_DONE : ST_LAG;
      end
      ST_LAG: begin
        if (lag_q > emax_q) begin
          state_d = ST_DONE;
        end else if (lag_fits) begin
          state_d = ST_PA;
        end
      end
      ST_PA: state_d = ST_PB;
      ST_PB: state_d = ST_PC;
      ST_PC: state_d = ST_PD;
      ST_PD: state_d = ST_PE;
      ST_PE: begin
        state_d = (k_q == n_q - N_W'(1)) ? ST_FLOAD : ST_PA;
      end
      ST_FLOAD: state_d = ST_FMUL;
      ST_FMUL: begin
        if (mul_last) state_d = ST_FPOST;
      end
      ST_FPOST: begin
        if (fin_q == F_RHS) begin
          state_d = ST_LAG;
        end else if (to_cmp && !have_q) begin
          state_d = ST_LAG;
        end else begin
          state_d = ST_FLOAD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    ram_we     = (state_q == ST_UPDATE) && (cnt_q != '0);
    ram_wdata  = {1'b0, price_q} - {1'b0, last_q};
    ram_raddr  = (state_q == ST_PB) ? yaddr_q : xaddr_q;
  end

  assign out_valid_o = out_valid_q;
  assign period_o    = period_q;

  always_comb begin
    fin_d       = fin_q;
    price_d     = price_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    head_d      = head_q;
    emax_d      = emax_q;
    lag_d       = lag_q;
    best_d      = best_q;
    span_d      = span_q;
    n_d         = n_q;
    k_d         = k_q;
    xaddr_d     = xaddr_q;
    yaddr_d     = yaddr_q;
    x_d         = x_q;
    y_d         = y_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    sxx_d       = sxx_q;
    syy_d       = syy_q;
    sxy_d       = sxy_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    la_d        = la_q;
    lb_d        = lb_q;
    i_d         = i_q;
    j_d         = j_q;
    acc_d       = acc_q;
    lhs_d       = lhs_q;
    t1_d        = t1_q;
    num_d       = num_q;
    dl_d        = dl_q;
    dr_d        = dr_q;
    n2_d        = n2_q;
    d_d         = d_q;
    bn2_d       = bn2_q;
    bd_d        = bd_q;
    have_d      = have_q;
    out_valid_d = out_valid_q;
    period_d    = period_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) price_d = price_i;
      end
      ST_UPDATE: begin
        if (cnt_q != '0) begin
          head_d = (head_q == PTR_W'(RING_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
        end
        last_d = price_q;
        if (cnt_q < CNT_W'(COUNT_CAP)) cnt_d = cnt_q + CNT_W'(1);
      end
      ST_SETUP: begin
        emax_d = LAG_W'(emax_w);
        lag_d  = LAG_W'(emin_w);
        best_d = (cnt_q < CNT_W'(MIN_SAMPLES)) ? '0 : LAG_W'(emin_w);
        span_d = CNT_W'(span_w);
        have_d = 1'b0;
      end
      ST_LAG: begin
        if (lag_q <= emax_q) begin
          if (lag_fits) begin
            n_d     = N_W'(pairs_w);
            k_d     = '0;
            sx_d    = '0;
            sy_d    = '0;
            sxx_d   = '0;
            syy_d   = '0;
            sxy_d   = '0;
            fin_d   = F_NSXY;
            xaddr_d = (head_q == '0) ? PTR_W'(RING_DEPTH - 1) : head_q - PTR_W'(1);
            yaddr_d = ybase[PTR_W] ? PTR_W'(ybase + (PTR_W + 1)'(RING_DEPTH))
                                   : ybase[PTR_W-1:0];
          end else begin
            lag_d = lag_q + LAG_W'(1);
          end
        end
      end
      ST_PA: ;
      ST_PB: begin
        x_d = $signed(ram_rdata);
      end
      ST_PC: begin
        y_d   = $signed(ram_rdata);
        sxx_d = sxx_q + SQ_W'(mul_p);
        sx_d  = sx_q + SUM_W'(x_q);
      end
      ST_PD: begin
        syy_d = syy_q + SQ_W'(mul_p);
        sy_d  = sy_q + SUM_W'(y_q);
      end
      ST_PE: begin
        sxy_d   = (x_q[DIFF_W-1] != y_q[DIFF_W-1]) ? sxy_q - pp_s : sxy_q + pp_s;
        k_d     = k_q + N_W'(1);
        xaddr_d = (xaddr_q == '0) ? PTR_W'(RING_DEPTH - 1) : xaddr_q - PTR_W'(1);
        yaddr_d = (yaddr_q == '0) ? PTR_W'(RING_DEPTH - 1) : yaddr_q - PTR_W'(1);
      end
      ST_FLOAD: begin
        acc_d = '0;
        i_d   = '0;
        j_d   = '0;
        unique case (fin_q)
          F_NSXY: begin
            opa_d = OP_W'(n_q);
            opb_d = OP_W'(sxymag);
            la_d  = IX_W'(LI_N);
            lb_d  = IX_W'(LI_Q);
          end
          F_SXSY: begin
            opa_d = OP_W'(sxmag);
            opb_d = OP_W'(symag);
            la_d  = IX_W'(LI_S);
            lb_d  = IX_W'(LI_S);
          end
          F_NSXX: begin
            opa_d = OP_W'(n_q);
            opb_d = OP_W'(sxx_q);
            la_d  = IX_W'(LI_N);
            lb_d  = IX_W'(LI_Q);
          end
          F_SXSX: begin
            opa_d = OP_W'(sxmag);
            opb_d = OP_W'(sxmag);
            la_d  = IX_W'(LI_S);
            lb_d  = IX_W'(LI_S);
          end
          F_NSYY: begin
            opa_d = OP_W'(n_q);
            opb_d = OP_W'(syy_q);
            la_d  = IX_W'(LI_N);
            lb_d  = IX_W'(LI_Q);
          end
          F_SYSY: begin
            opa_d = OP_W'(symag);
            opb_d = OP_W'(symag);
            la_d  = IX_W'(LI_S);
            lb_d  = IX_W'(LI_S);
          end
          F_NUM2: begin
            opa_d = OP_W'(nummag);
            opb_d = OP_W'(nummag);
            la_d  = IX_W'(LI_M);
            lb_d  = IX_W'(LI_M);
          end
          F_DEN: begin
            opa_d = OP_W'(dl_q);
            opb_d = OP_W'(dr_q);
            la_d  = IX_W'(LI_M);
            lb_d  = IX_W'(LI_M);
          end
          F_LHS: begin
            opa_d = OP_W'(n2_q);
            opb_d = OP_W'(bd_q);
            la_d  = IX_W'(LI_R);
            lb_d  = IX_W'(LI_R);
          end
          F_RHS: begin
            opa_d = OP_W'(bn2_q);
            opb_d = OP_W'(d_q);
            la_d  = IX_W'(LI_R);
            lb_d  = IX_W'(LI_R);
          end
          default: ;
        endcase
      end
      ST_FMUL: begin
        acc_d = acc_add;
        if (j_q == lb_q) begin
          j_d = '0;
          if (i_q != la_q) i_d = i_q + IX_W'(1);
        end else begin
          j_d = j_q + IX_W'(1);
        end
      end
      ST_FPOST: begin
        unique case (fin_q)
          F_NSXY: begin
            t1_d  = sxy_q[SQ_W] ? -accn : accn;
            fin_d = F_SXSY;
          end
          F_SXSY: begin
            num_d = (sx_q[SUM_W-1] != sy_q[SUM_W-1]) ? t1_q + accn : t1_q - accn;
            fin_d = F_NSXX;
          end
          F_NSXX: begin
            t1_d  = accn;
            fin_d = F_SXSX;
          end
          F_SXSX: begin
            dl_d  = NUM_W'(t1_q - accn);
            fin_d = F_NSYY;
          end
          F_NSYY: begin
            t1_d  = accn;
            fin_d = F_SYSY;
          end
          F_SYSY: begin
            dr_d  = dr_new;
            fin_d = F_NUM2;
          end
          F_NUM2: begin
            n2_d  = acc_q[SQR_W-1:0];
            fin_d = F_DEN;
          end
          F_LHS: begin
            lhs_d = acc_q;
            fin_d = F_RHS;
          end
          F_RHS: begin
            if (lhs_q > acc_q) begin
              best_d = lag_q;
              bn2_d  = n2_q;
              bd_d   = d_q;
            end
            lag_d = lag_q + LAG_W'(1);
            fin_d = F_NSXY;
          end
          default: ;
        endcase
        if (to_cmp) begin
          n2_d = n2_nx;
          d_d  = d_nx;
          if (!have_q) begin
            have_d = 1'b1;
            best_d = lag_q;
            bn2_d  = n2_nx;
            bd_d   = d_nx;
            lag_d  = lag_q + LAG_W'(1);
            fin_d  = F_NSXY;
          end else begin
            fin_d = F_LHS;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          period_d    = PERIOD_W'(best_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fin_q       <= F_NSXY;
      min_lag_q   <= MIN_LAG_RST;
      max_lag_q   <= MAX_LAG_RST;
      last_q      <= '0;
      cnt_q       <= '0;
      head_q      <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fin_q       <= fin_d;
      last_q      <= last_d;
      cnt_q       <= cnt_d;
      head_q      <= head_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite) begin
        unique case (reg_idx_e'(paddr[2]))
          REG_MIN_LAG: min_lag_q <= pwdata[CFG_W-1:0];
          REG_MAX_LAG: max_lag_q <= pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    price_q  <= price_d;
    emax_q   <= emax_d;
    lag_q    <= lag_d;
    best_q   <= best_d;
    span_q   <= span_d;
    n_q      <= n_d;
    k_q      <= k_d;
    xaddr_q  <= xaddr_d;
    yaddr_q  <= yaddr_d;
    x_q      <= x_d;
    y_q      <= y_d;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    sxx_q    <= sxx_d;
    syy_q    <= syy_d;
    sxy_q    <= sxy_d;
    opa_q    <= opa_d;
    opb_q    <= opb_d;
    la_q     <= la_d;
    lb_q     <= lb_d;
    i_q      <= i_d;
    j_q      <= j_d;
    acc_q    <= acc_d;
    lhs_q    <= lhs_d;
    t1_q     <= t1_d;
    num_q    <= num_d;
    dl_q     <= dl_d;
    dr_q     <= dr_d;
    n2_q     <= n2_d;
    d_q      <= d_d;
    bn2_q    <= bn2_d;
    bd_q     <= bd_d;
    period_q <= period_d;
  end

endmodule

// ----- rtl/core/acdp_checker.sv -----
module acdp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [acdp_pkg::PERIOD_W-1:0] period_o,
  input logic                          pready
);

  // A stalled result beat must hold its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(period_o))
    else $error("stalled result beat changed");

  // Once a sample is taken, the block is busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a sample is in work");

  // A new result only appears after the input has been closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without work");

  // The register port never inserts wait states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind autocorr_dominant_period acdp_checker u_acdp_checker (.*);

// ----- verif/tb_top.sv -----
module tb_top;
  import acdp_pkg::*;

  localparam int unsigned PERIOD_LIMIT = 63;
  localparam int unsigned COUNT_CAP = 2 * PERIOD_LIMIT + 2;
  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef logic signed [383:0] wide_t;

  class period_board;
    logic signed [DIFF_W-1:0] ring [128];
    logic [6:0] head;
    logic [PRICE_W-1:0] last;
    int unsigned count;
    int unsigned min_lag;
    int unsigned max_lag;
    logic [PERIOD_W-1:0] expected [$];
    int errors;

    function new();
      head = '0;
      last = '0;
      count = 0;
      min_lag = MIN_LAG_RST;
      max_lag = MAX_LAG_RST;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_e r, logic [CFG_W-1:0] v);
      if (r == REG_MIN_LAG) min_lag = v;
      else max_lag = v;
    endfunction

    function logic signed [DIFF_W-1:0] diff_at(int unsigned age);
      return ring[head - 7'd1 - age[6:0]];
    endfunction

    function logic [PERIOD_W-1:0] predict_period(logic [PRICE_W-1:0] price);
      wide_t bn2, bd, sxx, syy, sxy, wx, wy, wn, ws, wt, num, dl, dr, n2, d, lhs, rhs;
      longint sx, sy;
      int unsigned emin, emax, idx, win, start, span, lag, n, k, best;
      bit have;
      logic signed [DIFF_W-1:0] x, y;
      if (count > 0) begin
        ring[head] = $signed({1'b0, price}) - $signed({1'b0, last});
        head = head + 7'd1;
      end
      last = price;
      if (count < COUNT_CAP) count++;
      if (count < MIN_SAMPLES) return '0;
      emin = (min_lag < LAG_FLOOR) ? LAG_FLOOR : min_lag;
      if (emin > PERIOD_LIMIT - 2) emin = PERIOD_LIMIT - 2;
      emax = (max_lag < emin + LAG_GAP) ? emin + LAG_GAP : max_lag;
      if (emax > PERIOD_LIMIT) emax = PERIOD_LIMIT;
      idx = count - 1;
      if (idx < emax + 2) return emin[PERIOD_W-1:0];
      win = 2 * emax;
      start = (idx > win) ? idx - win : 1;
      span = idx - start;
      best = emin;
      have = 0;
      bn2 = '0;
      bd = '0;
      for (lag = emin; lag <= emax; lag++) begin
        if (lag > span) continue;
        n = span - lag + 1;
        if (n < MIN_PAIRS) continue;
        sx = 0;
        sy = 0;
        sxx = '0;
        syy = '0;
        sxy = '0;
        for (k = 0; k < n; k++) begin
          x = diff_at(k);
          y = diff_at(k + lag);
          wx = x;
          wy = y;
          sx += x;
          sy += y;
          sxx += wx * wx;
          syy += wy * wy;
          sxy += wx * wy;
        end
        wn = n;
        ws = sx;
        wt = sy;
        num = wn * sxy - ws * wt;
        dl = wn * sxx - ws * ws;
        dr = wn * syy - wt * wt;
        if (dl == 0 || dr == 0) begin
          n2 = '0;
          d = 1;
        end else begin
          n2 = num * num;
          d = dl * dr;
        end
        if (!have) begin
          have = 1;
          best = lag;
          bn2 = n2;
          bd = d;
          continue;
        end
        lhs = n2 * bd;
        rhs = bn2 * d;
        if (lhs > rhs) begin
          best = lag;
          bn2 = n2;
          bd = d;
        end
      end
      return best[PERIOD_W-1:0];
    endfunction

    function void note_sample(logic [PRICE_W-1:0] price);
      expected.push_back(predict_period(price));
    endfunction

    function void check_period(logic [PERIOD_W-1:0] got);
      logic [PERIOD_W-1:0] want;
      if (expected.size() == 0) begin
        $error("period: expected none, actual %0d", got);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (want !== got) begin
        $error("period: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [PRICE_W-1:0] price_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [PERIOD_W-1:0] period_o;

  period_board board = new();
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;
  int unsigned cycles = 0;
  int unsigned wave_t = 0;

  autocorr_dominant_period dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .price_i(price_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .period_o(period_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (rst_ni && in_valid_i && in_ready_o) board.note_sample(price_i);
    if (rst_ni && out_valid_o && out_ready_i) board.check_period(period_o);
  end

  initial begin : receiver
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (4000) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_price(logic [PRICE_W-1:0] p);
    in_valid_i <= 1'b1;
    price_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() > 0) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e r, logic [CFG_W-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= {$urandom} & ~32'h3f | v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    board.set_reg(r, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_limits(logic [CFG_W-1:0] lo, logic [CFG_W-1:0] hi);
    write_reg(REG_MIN_LAG, lo);
    @(posedge clk_i);
    write_reg(REG_MAX_LAG, hi);
  endtask

  function automatic logic [PRICE_W-1:0] next_price();
    int unsigned per, ph, amp;
    wave_t++;
    if ($urandom_range(0, 4) == 0) return $urandom;
    per = $urandom_range(5, 9);
    ph = wave_t % per;
    amp = $urandom_range(1, 1000);
    return 32'h8000_0000 + ph * amp * 997 + $urandom_range(0, 50);
  endfunction

  task automatic random_run(int unsigned count);
    repeat (count) send_price(next_price());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_price(32'h0000_0000);
    send_price(32'hffff_ffff);
    send_price(32'h0000_0000);
    send_price(32'hffff_ffff);
    drain();
    set_limits(6'd0, 6'd0);
    repeat (12) send_price(32'h1234_5678);
    send_price(32'h0000_0000);
    send_price(32'hffff_ffff);
    send_price(32'h0000_0000);
    send_price(32'hffff_ffff);
    send_price(32'h0000_0001);
    send_price(32'hffff_fffe);
    drain();

    hold_req = 1'b1;
    random_run(60);
    drain();

    set_limits(6'd61, 6'd63);
    random_run(15);
    drain();

    set_limits(6'd5, 6'd63);
    random_run(4);
    drain();

    set_limits(6'd20, 6'd10);
    random_run(20);
    drain();

    set_limits(6'd7, 6'd12);
    random_run(10);
    idle_en = 1'b0;
    random_run(10);
    drain();

    repeat (50) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
